[hw/rtl/esc_pkg.sv]
// Shared types and constants for the environmental sensor compensation pipeline.
// Used by every module under hw/rtl except esc_mul64; depends on nothing.
`timescale 1ns / 1ps

package esc_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_CAL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_CAL_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_CAL_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_CAL_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_CAL     = 3'd4;

  localparam logic [31:0] TEMP_ROUND    = 32'd128;
  localparam logic [31:0] HUM_T_OFS     = 32'd76800;
  localparam logic [31:0] HUM_A_ROUND   = 32'd16384;
  localparam logic [31:0] HUM_C_OFS     = 32'd32768;
  localparam logic [31:0] HUM_D_OFS     = 32'd2097152;
  localparam logic [31:0] HUM_E_ROUND   = 32'd8192;
  localparam logic [31:0] HUM_CLAMP_MAX = 32'd419430400;
  localparam logic [63:0] PRESS_T_OFS   = 64'd128000;
  localparam logic [20:0] PRESS_FULL    = 21'd1048576;
  localparam logic [63:0] PRESS_SCALE   = 64'd3125;
  localparam logic [63:0] PRESS_BIAS    = 64'h0000_8000_0000_0000;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic        [7:0]  h1;
    logic signed [15:0] h2;
    logic        [7:0]  h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } esc_cal_t;

  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
  } esc_div_in_t;

  typedef struct packed {
    logic        neg;
    logic        zero;
    logic [31:0] temp;
    logic [16:0] hum;
  } esc_side_t;

  typedef struct packed {
    logic [16:0] hum;
    logic [31:0] press;
    logic [31:0] temp;
  } esc_res_t;

endpackage

[hw/rtl/esc_mul64.sv]
// Two-stage multiplier giving the low 64 bits of a 64x64 product.
// Built from 32x32 partial products; uses no package items.
`timescale 1ns / 1ps

module esc_mul64 (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0] ll_r;
  logic [31:0] lh_r;
  logic [31:0] hl_r;
  logic [63:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= 64'(a[31:0]) * 64'(b[31:0]);
      lh_r <= a[31:0] * b[63:32];
      hl_r <= a[63:32] * b[31:0];
      p_r  <= ll_r + {lh_r + hl_r, 32'b0};
    end
  end

  assign p = p_r;

endmodule

[hw/rtl/esc_front.sv]
// Front pipeline: temperature, humidity, and pressure terms up to the divider operands.
// Depends on esc_pkg and esc_mul64.
`timescale 1ns / 1ps

module esc_front
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [19:0] adc_p,
  input  logic [19:0] adc_t,
  input  logic [15:0] adc_h,
  input  esc_cal_t    cal,
  output logic        out_vld,
  output esc_div_in_t out_div,
  output esc_side_t   out_side
);

  localparam int unsigned NSTG = 13;

  logic        vld_r [1:NSTG];
  logic [19:0] adcp_r [1:8];
  logic [15:0] adch_r [1:4];
  logic [31:0] temp_r [4:12];
  logic [16:0] hum_r [11:12];

  logic [31:0] s1_at_r, s1_dd_r;
  logic [31:0] s2_v1t_r, s2_m_r;
  logic [31:0] s3_f_r;
  logic [31:0] s4_x_r;
  logic [63:0] s4_pv1_r;
  logic [31:0] s5_ha_r, s5_b_r, s5_c_r;
  logic [31:0] s6_ha_r, s6_bc_r;
  logic [31:0] s7_ha_r, s7_dh_r;
  logic [31:0] s8_y_r;
  logic [31:0] s9_y_r, s9_ss_r;
  logic [31:0] s10_y_r, s10_sh_r;
  logic [63:0] v1p5_r [7:8];
  logic [63:0] v1p2_r [7:8];
  logic [63:0] s9_v2_r, s9_v1x_r, s9_pt_r;
  logic [63:0] s10_nb_r;
  logic [63:0] s12_den_r;
  esc_div_in_t div_r;
  esc_side_t   side_r;

  logic signed [17:0] ta, td;
  logic [31:0] ta32, td32, dd12, f5, h5x, ha_pre;
  logic [31:0] hb, hc, hd, he, hs, y2, yc;
  logic [20:0] pdif;
  logic [63:0] sq, v1p5, v1p2, v2a, vq3, denp, nump;

  assign ta   = $signed({1'b0, adc_t[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
  assign td   = $signed({2'b0, adc_t[19:4]}) - $signed({2'b0, cal.t1});
  assign ta32 = 32'(ta);
  assign td32 = 32'(td);
  assign dd12 = 32'($signed(s1_dd_r) >>> 12);
  assign f5   = {s3_f_r[29:0], 2'b0} + s3_f_r + TEMP_ROUND;
  assign h5x  = 32'(cal.h5) * s4_x_r;
  assign ha_pre = {2'b0, adch_r[4], 14'b0} - {cal.h4, 20'b0} - h5x + HUM_A_ROUND;
  assign hb   = 32'($signed(s5_b_r) >>> 10);
  assign hc   = 32'($signed(s5_c_r) >>> 11) + HUM_C_OFS;
  assign hd   = 32'($signed(s6_bc_r) >>> 10) + HUM_D_OFS;
  assign he   = 32'($signed(s7_dh_r) >>> 14);
  assign hs   = 32'($signed(s8_y_r) >>> 15);
  assign y2   = s10_y_r - 32'($signed(s10_sh_r) >>> 4);
  assign pdif = PRESS_FULL - {1'b0, adcp_r[8]};

  always_comb begin
    if (y2[31]) begin
      yc = '0;
    end else if (y2 > HUM_CLAMP_MAX) begin
      yc = HUM_CLAMP_MAX;
    end else begin
      yc = y2;
    end
  end

  esc_mul64 u_mul_sq (.clk, .en, .a(s4_pv1_r), .b(s4_pv1_r), .p(sq));
  esc_mul64 u_mul_p5 (.clk, .en, .a(s4_pv1_r), .b(64'(cal.p5)), .p(v1p5));
  esc_mul64 u_mul_p2 (.clk, .en, .a(s4_pv1_r), .b(64'(cal.p2)), .p(v1p2));
  esc_mul64 u_mul_p6 (.clk, .en, .a(sq), .b(64'(cal.p6)), .p(v2a));
  esc_mul64 u_mul_p3 (.clk, .en, .a(sq), .b(64'(cal.p3)), .p(vq3));
  esc_mul64 u_mul_p1 (.clk, .en, .a(s9_v1x_r), .b({48'b0, cal.p1}), .p(denp));
  esc_mul64 u_mul_sc (.clk, .en, .a(s10_nb_r), .b(PRESS_SCALE), .p(nump));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= NSTG; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[1] <= in_vld;
      for (int i = 2; i <= NSTG; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adcp_r[1] <= adc_p;
      for (int i = 2; i <= 8; i++) begin
        adcp_r[i] <= adcp_r[i-1];
      end
      adch_r[1] <= adc_h;
      for (int i = 2; i <= 4; i++) begin
        adch_r[i] <= adch_r[i-1];
      end
      // temperature
      s1_at_r  <= ta32 * 32'(cal.t2);
      s1_dd_r  <= td32 * td32;
      s2_v1t_r <= 32'($signed(s1_at_r) >>> 11);
      s2_m_r   <= dd12 * 32'(cal.t3);
      s3_f_r   <= s2_v1t_r + 32'($signed(s2_m_r) >>> 14);
      temp_r[4] <= 32'($signed(f5) >>> 8);
      for (int i = 5; i <= 12; i++) begin
        temp_r[i] <= temp_r[i-1];
      end
      s4_x_r   <= s3_f_r - HUM_T_OFS;
      s4_pv1_r <= 64'($signed(s3_f_r)) - PRESS_T_OFS;
      // humidity
      s5_ha_r  <= 32'($signed(ha_pre) >>> 15);
      s5_b_r   <= s4_x_r * 32'(cal.h6);
      s5_c_r   <= s4_x_r * {24'b0, cal.h3};
      s6_ha_r  <= s5_ha_r;
      s6_bc_r  <= hb * hc;
      s7_ha_r  <= s6_ha_r;
      s7_dh_r  <= hd * 32'(cal.h2) + HUM_E_ROUND;
      s8_y_r   <= s7_ha_r * he;
      s9_y_r   <= s8_y_r;
      s9_ss_r  <= hs * hs;
      s10_y_r  <= s9_y_r;
      s10_sh_r <= 32'($signed(s9_ss_r) >>> 7) * {24'b0, cal.h1};
      hum_r[11] <= yc[28:12];
      hum_r[12] <= hum_r[11];
      // pressure
      v1p5_r[7] <= v1p5;
      v1p5_r[8] <= v1p5_r[7];
      v1p2_r[7] <= v1p2;
      v1p2_r[8] <= v1p2_r[7];
      s9_v2_r  <= v2a + {v1p5_r[8][46:0], 17'b0} + {64'(cal.p4) << 35};
      s9_v1x_r <= 64'($signed(vq3) >>> 8) + {v1p2_r[8][51:0], 12'b0} + PRESS_BIAS;
      s9_pt_r  <= 64'(pdif) << 31;
      s10_nb_r <= s9_pt_r - s9_v2_r;
      s12_den_r <= 64'($signed(denp) >>> 33);
      div_r.num <= nump[63] ? (64'd0 - nump) : nump;
      div_r.den <= s12_den_r[63] ? (64'd0 - s12_den_r) : s12_den_r;
      side_r.neg  <= nump[63] ^ s12_den_r[63];
      side_r.zero <= (s12_den_r == 64'd0);
      side_r.temp <= temp_r[12];
      side_r.hum  <= hum_r[12];
    end
  end

  assign out_vld  = vld_r[NSTG];
  assign out_div  = div_r;
  assign out_side = side_r;

endmodule

[hw/rtl/esc_div64.sv]
// Pipelined 64-bit unsigned restoring divider, one quotient bit per stage.
// Depends on esc_pkg for the divider operand and side-band item types.
`timescale 1ns / 1ps

module esc_div64
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  esc_div_in_t in_div,
  input  esc_side_t   in_side,
  output logic        out_vld,
  output logic [63:0] out_quo,
  output esc_side_t   out_side
);

  localparam int unsigned NBIT = 64;

  logic        vld_r  [0:NBIT-1];
  logic [63:0] rem_r  [0:NBIT-1];
  logic [63:0] nq_r   [0:NBIT-1];
  logic [63:0] den_r  [0:NBIT-1];
  esc_side_t   side_r [0:NBIT-1];

  for (genvar k = 0; k < NBIT; k++) begin : g_stg
    logic        vld_in;
    logic [63:0] rem_in, nq_in, den_in;
    esc_side_t   side_in;
    logic [64:0] trial, diff;
    logic        take;

    if (k == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = '0;
      assign nq_in   = in_div.num;
      assign den_in  = in_div.den;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign nq_in   = nq_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign trial = {rem_in, nq_in[63]};
    assign diff  = trial - {1'b0, den_in};
    assign take  = !diff[64];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? diff[63:0] : trial[63:0];
        nq_r[k]   <= {nq_in[62:0], take};
        den_r[k]  <= den_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[NBIT-1];
  assign out_quo  = nq_r[NBIT-1];
  assign out_side = side_r[NBIT-1];

endmodule

[hw/rtl/esc_back.sv]
// Back pipeline: signed quotient, second-order pressure terms, final result word.
// Depends on esc_pkg and esc_mul64.
`timescale 1ns / 1ps

module esc_back
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [63:0] in_quo,
  input  esc_side_t   in_side,
  input  esc_cal_t    cal,
  output logic        out_vld,
  output esc_res_t    out_res
);

  localparam int unsigned NSTG = 7;

  logic        vld_r  [1:NSTG];
  esc_side_t   side_r [1:6];
  logic [63:0] p_r    [1:5];
  logic [63:0] x_r    [2:3];
  logic [63:0] m9_r   [4:5];
  logic [63:0] sum_r;
  esc_res_t    res_r;

  logic [63:0] x, m8, m9, m10, fin;

  assign x   = 64'($signed(p_r[1]) >>> 13);
  assign fin = 64'($signed(sum_r) >>> 8) + (64'(cal.p7) << 4);

  esc_mul64 u_mul_p9 (.clk, .en, .a(64'(cal.p9)), .b(x), .p(m8));
  esc_mul64 u_mul_p8 (.clk, .en, .a(64'(cal.p8)), .b(p_r[1]), .p(m9));
  esc_mul64 u_mul_xx (.clk, .en, .a(m8), .b(x_r[3]), .p(m10));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= NSTG; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[1] <= in_vld;
      for (int i = 2; i <= NSTG; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[1] <= in_side;
      for (int i = 2; i <= 6; i++) begin
        side_r[i] <= side_r[i-1];
      end
      p_r[1] <= in_side.neg ? (64'd0 - in_quo) : in_quo;
      for (int i = 2; i <= 5; i++) begin
        p_r[i] <= p_r[i-1];
      end
      x_r[2]  <= x;
      x_r[3]  <= x_r[2];
      m9_r[4] <= m9;
      m9_r[5] <= m9_r[4];
      sum_r <= p_r[5] + 64'($signed(m10) >>> 25) + 64'($signed(m9_r[5]) >>> 19);
      res_r.temp  <= side_r[6].temp;
      res_r.hum   <= side_r[6].hum;
      res_r.press <= side_r[6].zero ? 32'd0 : fin[31:0];
    end
  end

  assign out_vld = vld_r[NSTG];
  assign out_res = res_r;

endmodule

[hw/rtl/env_sensor_compensation.sv]
// Environmental sensor trim compensation, top level.
// Holds the trim registers, the output register and the pipeline stall control.
// Depends on esc_pkg, esc_front, esc_div64 and esc_back.
//
// Usage:
//   in_*  : one item per handshake = raw pressure, temperature, humidity readings.
//   out_* : one item per input item = temperature (0.01 degC), pressure (Pa Q24.8),
//           humidity (%RH Q7.10), in input order.
//   cfg_* : trim register writes by index; cfg_ready is always high. Write only
//           while no item is in flight.
// Path: out_tvalid rises once an accepted item has passed 13 front stages,
//   64 divider stages, 7 back stages and the output register.
// Throughput: one item per cycle unless stalled, set by the 64-stage pipelined
//   divider, one quotient bit per stage.
// Reset: clears all trim registers and every stage valid bit; no item in flight.
// Stall: when out_tready is low the whole pipeline holds, except that it advances
//   while its last stage or the output register is empty, so input is taken while a
//   finished item waits in the output register. Nothing is lost or repeated.
`timescale 1ns / 1ps

module env_sensor_compensation
  import esc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [55:0]          in_tdata,   // adc_pressure[19:0], adc_temperature, adc_humidity
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [87:0]          out_tdata,  // temperature_centi[31:0], pressure_q24_8, humidity_q7_10
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  logic [47:0] temp_cal_r;
  logic [63:0] press_cal_a_r;
  logic [63:0] press_cal_b_r;
  logic [15:0] press_cal_c_r;
  logic [63:0] hum_cal_r;
  esc_cal_t    cal;

  logic        pipe_en;
  logic        out_load;
  logic        front_vld, div_vld, back_vld;
  esc_div_in_t front_div;
  esc_side_t   front_side, div_side;
  logic [63:0] div_quo;
  esc_res_t    back_res;
  logic        out_valid_r;
  esc_res_t    out_res_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r    <= '0;
      press_cal_a_r <= '0;
      press_cal_b_r <= '0;
      press_cal_c_r <= '0;
      hum_cal_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TEMP_CAL:    temp_cal_r    <= cfg_data[47:0];
        REG_PRESS_CAL_A: press_cal_a_r <= cfg_data;
        REG_PRESS_CAL_B: press_cal_b_r <= cfg_data;
        REG_PRESS_CAL_C: press_cal_c_r <= cfg_data[15:0];
        REG_HUM_CAL:     hum_cal_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.t1 = temp_cal_r[15:0];
    cal.t2 = temp_cal_r[31:16];
    cal.t3 = temp_cal_r[47:32];
    cal.p1 = press_cal_a_r[15:0];
    cal.p2 = press_cal_a_r[31:16];
    cal.p3 = press_cal_a_r[47:32];
    cal.p4 = press_cal_a_r[63:48];
    cal.p5 = press_cal_b_r[15:0];
    cal.p6 = press_cal_b_r[31:16];
    cal.p7 = press_cal_b_r[47:32];
    cal.p8 = press_cal_b_r[63:48];
    cal.p9 = press_cal_c_r;
    cal.h1 = hum_cal_r[7:0];
    cal.h2 = hum_cal_r[23:8];
    cal.h3 = hum_cal_r[31:24];
    cal.h4 = hum_cal_r[43:32];
    cal.h5 = hum_cal_r[55:44];
    cal.h6 = hum_cal_r[63:56];
  end

  assign out_load  = !out_valid_r || out_tready;
  assign pipe_en   = out_load || !back_vld;
  assign in_tready = pipe_en;

  esc_front u_front (
    .clk,
    .rst_n,
    .en       (pipe_en),
    .in_vld   (in_tvalid),
    .adc_p    (in_tdata[19:0]),
    .adc_t    (in_tdata[39:20]),
    .adc_h    (in_tdata[55:40]),
    .cal,
    .out_vld  (front_vld),
    .out_div  (front_div),
    .out_side (front_side)
  );

  esc_div64 u_div (
    .clk,
    .rst_n,
    .en       (pipe_en),
    .in_vld   (front_vld),
    .in_div   (front_div),
    .in_side  (front_side),
    .out_vld  (div_vld),
    .out_quo  (div_quo),
    .out_side (div_side)
  );

  esc_back u_back (
    .clk,
    .rst_n,
    .en      (pipe_en),
    .in_vld  (div_vld),
    .in_quo  (div_quo),
    .in_side (div_side),
    .cal,
    .out_vld (back_vld),
    .out_res (back_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= back_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= back_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_res_r};

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready && back_vld))
    else $error("input stalled without a blocked result");

  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> ($stable(back_res) && back_vld))
    else $error("last stage changed during stall");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[80:64] <= 17'd102400))
    else $error("humidity out of range");

endmodule

[dv/testbench.sv]
// Testbench for env_sensor_compensation: random and directed readings under several trim sets.
// Results are checked against a scoreboard with its own integer compensation predictor.
// Depends on esc_pkg and the RTL under hw/rtl.
`timescale 1ns / 1ps

module testbench;
  import esc_pkg::*;

  typedef struct {
    logic [31:0] temp;
    logic [31:0] press;
    logic [16:0] hum;
  } reading_t;

  class comp_scoreboard;
    logic [47:0] temp_trim;
    logic [63:0] press_trim_a, press_trim_b, hum_trim;
    logic [15:0] press_trim_c;
    reading_t    expected_q[$];
    int          errors;

    function new();
      temp_trim = '0; press_trim_a = '0; press_trim_b = '0;
      press_trim_c = '0; hum_trim = '0; errors = 0;
    endfunction

    function void report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void write_trim(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
      case (idx)
        REG_TEMP_CAL:    temp_trim = val[47:0];
        REG_PRESS_CAL_A: press_trim_a = val;
        REG_PRESS_CAL_B: press_trim_b = val;
        REG_PRESS_CAL_C: press_trim_c = val[15:0];
        REG_HUM_CAL:     hum_trim = val;
        default: ;
      endcase
    endfunction

    function logic [31:0] asr32(logic [31:0] x, int n);
      return $unsigned($signed(x) >>> n);
    endfunction

    function logic [63:0] asr64(logic [63:0] x, int n);
      return $unsigned($signed(x) >>> n);
    endfunction

    function logic [63:0] sdiv64(logic [63:0] a, logic [63:0] b);
      logic [63:0] ma, mb, q;
      ma = a[63] ? 64'd0 - a : a;
      mb = b[63] ? 64'd0 - b : b;
      q = ma / mb;
      return (a[63] != b[63]) ? 64'd0 - q : q;
    endfunction

    function void note_input(logic [19:0] adc_p, logic [19:0] adc_t, logic [15:0] adc_h);
      logic [31:0] t1, t2, t3, a, d, v1, v2, fine;
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, w1, w2, p;
      logic [31:0] h1, h2, h3, h4, h5, h6, x, ha, hb, hc, hd, he, y, s;
      reading_t r;
      t1 = {16'd0, temp_trim[15:0]};
      t2 = {{16{temp_trim[31]}}, temp_trim[31:16]};
      t3 = {{16{temp_trim[47]}}, temp_trim[47:32]};
      a = ({12'd0, adc_t} >> 3) - (t1 << 1);
      d = ({12'd0, adc_t} >> 4) - t1;
      v1 = asr32(a * t2, 11);
      v2 = asr32(asr32(d * d, 12) * t3, 14);
      fine = v1 + v2;
      r.temp = asr32(fine * 32'd5 + 32'd128, 8);

      p1 = {48'd0, press_trim_a[15:0]};
      p2 = {{48{press_trim_a[31]}}, press_trim_a[31:16]};
      p3 = {{48{press_trim_a[47]}}, press_trim_a[47:32]};
      p4 = {{48{press_trim_a[63]}}, press_trim_a[63:48]};
      p5 = {{48{press_trim_b[15]}}, press_trim_b[15:0]};
      p6 = {{48{press_trim_b[31]}}, press_trim_b[31:16]};
      p7 = {{48{press_trim_b[47]}}, press_trim_b[47:32]};
      p8 = {{48{press_trim_b[63]}}, press_trim_b[63:48]};
      p9 = {{48{press_trim_c[15]}}, press_trim_c};
      w1 = {{32{fine[31]}}, fine} - 64'd128000;
      w2 = w1 * w1 * p6;
      w2 = w2 + ((w1 * p5) << 17);
      w2 = w2 + (p4 << 35);
      w1 = asr64(w1 * w1 * p3, 8) + ((w1 * p2) << 12);
      w1 = asr64(((64'd1 << 47) + w1) * p1, 33);
      if (w1 == 64'd0) begin
        r.press = 32'd0;
      end else begin
        p = 64'd1048576 - {44'd0, adc_p};
        p = sdiv64(((p << 31) - w2) * 64'd3125, w1);
        w1 = asr64(p9 * asr64(p, 13) * asr64(p, 13), 25);
        w2 = asr64(p8 * p, 19);
        p = asr64(p + w1 + w2, 8) + (p7 << 4);
        r.press = p[31:0];
      end

      h1 = {24'd0, hum_trim[7:0]};
      h2 = {{16{hum_trim[23]}}, hum_trim[23:8]};
      h3 = {24'd0, hum_trim[31:24]};
      h4 = {{20{hum_trim[43]}}, hum_trim[43:32]};
      h5 = {{20{hum_trim[55]}}, hum_trim[55:44]};
      h6 = {{24{hum_trim[63]}}, hum_trim[63:56]};
      x = fine - 32'd76800;
      ha = asr32(({16'd0, adc_h} << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
      hb = asr32(x * h6, 10);
      hc = asr32(x * h3, 11) + 32'd32768;
      hd = asr32(hb * hc, 10) + 32'd2097152;
      he = asr32(hd * h2 + 32'd8192, 14);
      y = ha * he;
      s = asr32(y, 15);
      y = y - asr32(asr32(s * s, 7) * h1, 4);
      if (y[31]) y = 32'd0;
      else if (y > 32'd419430400) y = 32'd419430400;
      y = y >> 12;
      r.hum = y[16:0];
      expected_q.push_back(r);
    endfunction

    function void check(logic [87:0] data);
      reading_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected: %h", data));
        return;
      end
      e = expected_q.pop_front();
      if (data[31:0] !== e.temp)
        report($sformatf("temperature %h, expected %h", data[31:0], e.temp));
      if (data[63:32] !== e.press)
        report($sformatf("pressure %h, expected %h", data[63:32], e.press));
      if (data[80:64] !== e.hum)
        report($sformatf("humidity %h, expected %h", data[80:64], e.hum));
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [55:0]          in_tdata;   // adc_pressure[19:0], adc_temperature, adc_humidity
  logic                 out_tvalid;
  logic                 out_tready;
  logic [87:0]          out_tdata;  // temperature_centi[31:0], pressure_q24_8, humidity_q7_10
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_data;

  comp_scoreboard sb = new();
  bit tx_idle;
  bit rx_idle;
  bit hold_req;

  env_sensor_compensation dut (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata);
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic [19:0] ap, logic [19:0] at, logic [15:0] ah);
    bit ok;
    in_tvalid <= 1'b1;
    in_tdata <= {ah, at, ap};
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
    sb.note_input(ap, at, ah);
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic send_random(int n);
    logic [19:0] ap, at;
    logic [15:0] ah;
    repeat (n) begin
      ap = 20'($urandom);
      at = 20'($urandom);
      ah = 16'($urandom);
      case ($urandom_range(0, 9))
        0: ap = $urandom_range(0, 1) ? 20'hFFFFF : 20'h0;
        1: at = $urandom_range(0, 1) ? 20'hFFFFF : 20'h0;
        2: ah = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
        3: at = 20'(20'd400000 + $urandom_range(0, 250000));
        default: ;
      endcase
      send_item(ap, at, ah);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  task automatic write_trim(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    sb.write_trim(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_trims(logic [63:0] t, logic [63:0] a, logic [63:0] b,
                            logic [63:0] c, logic [63:0] h);
    write_trim(REG_TEMP_CAL, t);
    write_trim(REG_PRESS_CAL_A, a);
    write_trim(REG_PRESS_CAL_B, b);
    write_trim(REG_PRESS_CAL_C, c);
    write_trim(REG_HUM_CAL, h);
  endtask

  task automatic directed_set();
    send_item(20'h0, 20'h0, 16'h0);
    send_item(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_item(20'h0, 20'hFFFFF, 16'h0);
    send_item(20'hFFFFF, 20'h0, 16'hFFFF);
    send_item(20'd415148, 20'd519888, 16'd27000);
    send_item(20'd300000, 20'd550000, 16'd0);
    send_item(20'd300000, 20'd480000, 16'hFFFF);
  endtask

  localparam logic [63:0] TYP_T = 64'({16'hFC18, 16'd26435, 16'd27504});
  localparam logic [63:0] TYP_A = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
  localparam logic [63:0] TYP_B = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
  localparam logic [63:0] TYP_H = {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75};

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_req = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset trims: zero pressure divisor
    directed_set();
    drain();

    load_trims(TYP_T, TYP_A, TYP_B, 64'd6000, TYP_H);
    write_trim(3'(REG_HUM_CAL + 1), '1);
    write_trim('1, '1);
    directed_set();
    send_random(400);
    drain();

    load_trims('1, '1, '1, '1, '1);
    directed_set();
    send_random(100);
    drain();

    load_trims(64'({16'h7FFF, 16'h7FFF, 16'hFFFF}), {4{16'h7FFF}} | 64'hFFFF,
               {4{16'h7FFF}}, 64'h7FFF, {8'h7F, 12'h7FF, 12'h7FF, 8'hFF, 16'h7FFF, 8'hFF});
    send_random(100);
    drain();

    load_trims(64'({16'h8000, 16'h8000, 16'h0000}), {4{16'h8000}}, {4{16'h8000}},
               64'h8000, {8'h80, 12'h800, 12'h800, 8'h00, 16'h8000, 8'h00});
    send_random(100);
    drain();

    repeat (3) begin
      load_trims({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
      send_random(300);
      drain();
    end

    // long receiver hold-off with the sender pushing back to back
    load_trims(TYP_T, TYP_A, TYP_B, 64'd6000, TYP_H);
    tx_idle = 1'b0;
    hold_req = 1'b1;
    send_random(250);
    drain();

    rx_idle = 1'b0;
    send_random(200);
    drain();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/esc_pkg.sv
hw/rtl/esc_mul64.sv
hw/rtl/esc_front.sv
hw/rtl/esc_div64.sv
hw/rtl/esc_back.sv
hw/rtl/env_sensor_compensation.sv
dv/testbench.sv
